/* hdl/drbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package drbm_pkg;

    // item commands
    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_START = 3'd2,
        CMD_END   = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    // track selector values
    localparam logic TRACK_MUSIC  = 1'b0;
    localparam logic TRACK_EFFECT = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MUSIC_SHIFT  = 2'd0,
        REG_EFFECT_SHIFT = 2'd1
    } reg_idx_t;

    localparam int unsigned SHIFT_W = 4;
    localparam int unsigned DAC_W   = 12;
    localparam int unsigned LEVEL_W = 12;

    localparam logic [SHIFT_W-1:0] MUSIC_SHIFT_RST  = 4'd2;
    localparam logic [SHIFT_W-1:0] EFFECT_SHIFT_RST = 4'd1;

    // mid-scale code, silence
    localparam logic [DAC_W-1:0] DAC_MID = 12'd2048;
    localparam logic [DAC_W-1:0] DAC_MAX = 12'd4095;

    // sum width: two 16-bit samples plus the 32768 offset
    localparam int unsigned MIX_W = 18;
    localparam logic signed [MIX_W-1:0] MIX_OFFSET = 18'sd32768;

endpackage

`default_nettype wire

/* hdl/dual_ring_buffer_audio_mixer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-track PCM mixer for a 12-bit DAC. Bytes pushed per track land in a ring
// buffer of BUFFER_BYTES bytes (BUFFER_BYTES-1 usable; a push into a full
// buffer is dropped and flagged). A sample tick pops one little-endian 16-bit
// sample from each active track, shifts each by its configured amount, sums,
// offsets and saturates into an unsigned 12-bit code. Every input item gives
// exactly one result item. One item is accepted per clock while s_tready is
// high. The read stage registers the buffer read, then the result register
// takes the mix stage output. Buffer levels and track flags in a result are
// those after the item took effect. Buffer contents are not cleared at reset.
module dual_ring_buffer_audio_mixer #(
    parameter int unsigned BUFFER_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: data_byte[7:0], loop_flag[8], zero fill
    input  wire logic [15:0] s_tdata,
    // s_tuser: command[2:0], track[3]
    input  wire logic [3:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: dac_code[11:0], music_level[23:12], effect_level[35:24],
    // music_active[36], effect_active[37], effect_playing[38],
    // byte_dropped[39]
    output logic [39:0]      m_tdata,
    // m_tuser: sample_valid[0]
    output logic             m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);

    localparam int unsigned PTR_W = $clog2(BUFFER_BYTES);
    localparam logic [PTR_W:0] DEPTH = (PTR_W+1)'(BUFFER_BYTES);
    localparam logic [PTR_W-1:0] FULL_LVL = PTR_W'(BUFFER_BYTES - 1);
    localparam logic [PTR_W-1:0] MIN_LVL = PTR_W'(2);

    // pointer advance modulo the buffer size
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [1:0] inc);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + (PTR_W+1)'(inc);
        if (sum >= DEPTH) begin
            sum = sum - DEPTH;
        end
        return sum[PTR_W-1:0];
    endfunction

    // bytes waiting between read and write pointer
    function automatic logic [PTR_W-1:0] level_of(input logic [PTR_W-1:0] rd,
                                                  input logic [PTR_W-1:0] wr);
        logic [PTR_W:0] diff;
        diff = {1'b0, wr} + DEPTH - {1'b0, rd};
        if (diff >= DEPTH) begin
            diff = diff - DEPTH;
        end
        return diff[PTR_W-1:0];
    endfunction

    // fit a level into the result field
    function automatic logic [drbm_pkg::LEVEL_W-1:0] level_out(input logic [PTR_W-1:0] lvl);
        logic [PTR_W+drbm_pkg::LEVEL_W-1:0] ext;
        ext = (PTR_W+drbm_pkg::LEVEL_W)'(lvl);
        return ext[drbm_pkg::LEVEL_W-1:0];
    endfunction

    // input fields
    logic [7:0]           in_byte;
    logic                 in_loop;
    drbm_pkg::cmd_t       in_cmd;
    logic                 in_track;
    logic                 s_acc;

    assign in_byte  = s_tdata[7:0];
    assign in_loop  = s_tdata[8];
    assign in_cmd   = drbm_pkg::cmd_t'(s_tuser[2:0]);
    assign in_track = s_tuser[3];
    assign s_acc    = s_tvalid && s_tready;

    // configuration registers
    logic [drbm_pkg::SHIFT_W-1:0] music_shift_reg, effect_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            music_shift_reg  <= drbm_pkg::MUSIC_SHIFT_RST;
            effect_shift_reg <= drbm_pkg::EFFECT_SHIFT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == drbm_pkg::REG_MUSIC_SHIFT) begin
                music_shift_reg <= cfg_data;
            end
            if (cfg_index == drbm_pkg::REG_EFFECT_SHIFT) begin
                effect_shift_reg <= cfg_data;
            end
        end
    end

    // track state
    logic [PTR_W-1:0] m_rd_reg, m_rd_next, m_wr_reg, m_wr_next;
    logic [PTR_W-1:0] e_rd_reg, e_rd_next, e_wr_reg, e_wr_next;
    logic [1:0]       active_reg, active_next;
    logic [1:0]       loop_reg, loop_next;
    logic             playing_reg, playing_next;

    logic [PTR_W-1:0] m_lvl, e_lvl;
    logic             m_take, e_take, dropped;
    logic             m_we, e_we;

    assign m_lvl = level_of(m_rd_reg, m_wr_reg);
    assign e_lvl = level_of(e_rd_reg, e_wr_reg);

    // command decode and state update
    always_comb begin
        m_rd_next    = m_rd_reg;
        m_wr_next    = m_wr_reg;
        e_rd_next    = e_rd_reg;
        e_wr_next    = e_wr_reg;
        active_next  = active_reg;
        loop_next    = loop_reg;
        playing_next = playing_reg;
        m_take       = 1'b0;
        e_take       = 1'b0;
        dropped      = 1'b0;
        m_we         = 1'b0;
        e_we         = 1'b0;
        if (s_acc) begin
            unique case (in_cmd)
                drbm_pkg::CMD_PUSH: begin
                    if (in_track == drbm_pkg::TRACK_EFFECT) begin
                        if (e_lvl >= FULL_LVL) begin
                            dropped = 1'b1;
                        end else begin
                            e_we      = 1'b1;
                            e_wr_next = ptr_add(e_wr_reg, 2'd1);
                        end
                    end else begin
                        if (m_lvl >= FULL_LVL) begin
                            dropped = 1'b1;
                        end else begin
                            m_we      = 1'b1;
                            m_wr_next = ptr_add(m_wr_reg, 2'd1);
                        end
                    end
                end
                drbm_pkg::CMD_TICK: begin
                    // music sample, or run dry
                    if (active_reg[0]) begin
                        if (m_lvl < MIN_LVL) begin
                            if (!loop_reg[0]) begin
                                active_next[0] = 1'b0;
                            end
                        end else begin
                            m_take    = 1'b1;
                            m_rd_next = ptr_add(m_rd_reg, 2'd2);
                        end
                    end
                    // effect only while playing; flag drops once inactive
                    if (playing_reg) begin
                        if (active_reg[1]) begin
                            if (e_lvl < MIN_LVL) begin
                                if (!loop_reg[1]) begin
                                    active_next[1] = 1'b0;
                                end
                            end else begin
                                e_take    = 1'b1;
                                e_rd_next = ptr_add(e_rd_reg, 2'd2);
                            end
                        end else begin
                            playing_next = 1'b0;
                        end
                    end
                end
                drbm_pkg::CMD_START: begin
                    if (in_track == drbm_pkg::TRACK_EFFECT) begin
                        e_rd_next    = '0;
                        e_wr_next    = '0;
                        playing_next = 1'b1;
                    end else begin
                        m_rd_next = '0;
                        m_wr_next = '0;
                    end
                    active_next[in_track] = 1'b1;
                    loop_next[in_track]   = in_loop;
                end
                drbm_pkg::CMD_END: begin
                    loop_next[in_track] = 1'b0;
                end
                drbm_pkg::CMD_STOP: begin
                    active_next  = '0;
                    playing_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_rd_reg    <= '0;
            m_wr_reg    <= '0;
            e_rd_reg    <= '0;
            e_wr_reg    <= '0;
            active_reg  <= '0;
            loop_reg    <= '0;
            playing_reg <= 1'b0;
        end else begin
            m_rd_reg    <= m_rd_next;
            m_wr_reg    <= m_wr_next;
            e_rd_reg    <= e_rd_next;
            e_wr_reg    <= e_wr_next;
            active_reg  <= active_next;
            loop_reg    <= loop_next;
            playing_reg <= playing_next;
        end
    end

    // ring buffers, one write and two registered reads each
    logic [7:0] music_mem [BUFFER_BYTES];
    logic [7:0] effect_mem [BUFFER_BYTES];
    logic [7:0] m_lo_reg, m_hi_reg, e_lo_reg, e_hi_reg;

    always_ff @(posedge aclk) begin
        if (m_we) begin
            music_mem[m_wr_reg] <= in_byte;
        end
        if (s_acc) begin
            m_lo_reg <= music_mem[m_rd_reg];
            m_hi_reg <= music_mem[ptr_add(m_rd_reg, 2'd1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            effect_mem[e_wr_reg] <= in_byte;
        end
        if (s_acc) begin
            e_lo_reg <= effect_mem[e_rd_reg];
            e_hi_reg <= effect_mem[ptr_add(e_rd_reg, 2'd1)];
        end
    end

    // read stage: item info travelling beside the buffer data
    logic                          st1_valid_reg, st1_valid_next;
    logic                          st1_tick_reg, st1_mtake_reg, st1_etake_reg, st1_drop_reg;
    logic [drbm_pkg::LEVEL_W-1:0]  st1_mlvl_reg, st1_elvl_reg;
    logic [1:0]                    st1_active_reg;
    logic                          st1_playing_reg;
    logic                          out_free;

    assign out_free = !m_tvalid || m_tready;
    assign s_tready = !st1_valid_reg || out_free;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_acc) begin
            st1_valid_next = 1'b1;
        end else if (out_free) begin
            st1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_tick_reg    <= (in_cmd == drbm_pkg::CMD_TICK);
            st1_mtake_reg   <= m_take;
            st1_etake_reg   <= e_take;
            st1_drop_reg    <= dropped;
            st1_mlvl_reg    <= level_out(level_of(m_rd_next, m_wr_next));
            st1_elvl_reg    <= level_out(level_of(e_rd_next, e_wr_next));
            st1_active_reg  <= active_next;
            st1_playing_reg <= playing_next;
        end
    end

    // mix stage: shift, sum, offset, saturate
    logic signed [15:0]              m_smp, e_smp, m_sh, e_sh;
    logic signed [drbm_pkg::MIX_W-1:0] mix;
    logic [drbm_pkg::DAC_W-1:0]      code;

    always_comb begin
        m_smp = st1_mtake_reg ? $signed({m_hi_reg, m_lo_reg}) : 16'sd0;
        e_smp = st1_etake_reg ? $signed({e_hi_reg, e_lo_reg}) : 16'sd0;
        m_sh  = m_smp >>> music_shift_reg;
        e_sh  = e_smp >>> effect_shift_reg;
        mix   = $signed({{2{m_sh[15]}}, m_sh}) + $signed({{2{e_sh[15]}}, e_sh})
                + drbm_pkg::MIX_OFFSET;
        if (!st1_tick_reg) begin
            code = drbm_pkg::DAC_MID;
        end else if (mix[drbm_pkg::MIX_W-1]) begin
            code = '0;
        end else if (mix[16]) begin
            code = drbm_pkg::DAC_MAX;
        end else begin
            code = mix[15:4];
        end
    end

    // result register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_free) begin
            m_tvalid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_valid_reg && out_free) begin
            m_tdata_reg <= {st1_drop_reg, st1_playing_reg, st1_active_reg[1],
                            st1_active_reg[0], st1_elvl_reg, st1_mlvl_reg, code};
            m_tuser_reg <= st1_tick_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* hdl/drbm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module drbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [15:0] s_tdata,
    input wire logic [3:0]  s_tuser,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // non-tick results carry mid-scale silence
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[11:0] == drbm_pkg::DAC_MID)
        else $error("non-tick result without mid-scale code");

    // a dropped byte only comes from a push, never from a tick
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39] |-> !m_tuser)
        else $error("drop flag on a tick result");

    // a result stalled downstream keeps the input side from taking two items
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s_tvalid && s_tready |=> !(m_tvalid && !m_tready)
        || !s_tready)
        else $error("input taken with both stages full");

endmodule

bind dual_ring_buffer_audio_mixer drbm_checker u_drbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    // command codes with no effect
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT = 40000;
    localparam int RING_BYTES  = 4096;

    // one mixer result, split into its fields
    typedef struct packed {
        logic [drbm_pkg::DAC_W-1:0]   dac;
        logic                         sample_valid;
        logic [drbm_pkg::LEVEL_W-1:0] music_level;
        logic [drbm_pkg::LEVEL_W-1:0] effect_level;
        logic                         music_active;
        logic                         effect_active;
        logic                         effect_playing;
        logic                         byte_dropped;
    } mix_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [15:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;

    // mirror of the mixer state
    logic [7:0]                   music_bytes [RING_BYTES];
    logic [7:0]                   effect_bytes [RING_BYTES];
    logic [drbm_pkg::LEVEL_W-1:0] music_rd, music_wr, effect_rd, effect_wr;
    logic [1:0]                   active_bits, loop_bits;
    logic                         playing;
    logic [drbm_pkg::SHIFT_W-1:0] music_sh, effect_sh;

    mix_result_t expected_mix_q[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          idle_pct    = 28;

    dual_ring_buffer_audio_mixer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #4 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // pop one sample from a track, deactivating it when it runs dry
    function automatic int pop_sample(input logic trk);
        logic [drbm_pkg::LEVEL_W-1:0] rd, wr, lvl, rd_next;
        logic [15:0]                  raw;
        rd  = trk ? effect_rd : music_rd;
        wr  = trk ? effect_wr : music_wr;
        lvl = wr - rd;
        if (!active_bits[trk])
            return 0;
        if (lvl < 12'd2) begin
            if (!loop_bits[trk])
                active_bits[trk] = 1'b0;
            return 0;
        end
        rd_next = rd + 12'd1;
        if (trk) begin
            raw       = {effect_bytes[rd_next], effect_bytes[rd]};
            effect_rd = rd + 12'd2;
        end else begin
            raw      = {music_bytes[rd_next], music_bytes[rd]};
            music_rd = rd + 12'd2;
        end
        return $signed(raw);
    endfunction

    // expected result of one item, queued in order
    function automatic void mix_predict(input logic [2:0] cmd, input logic trk,
                                        input logic [7:0] data, input logic lp);
        mix_result_t r;
        int          m, e, mixed;
        r = '0;
        r.dac = drbm_pkg::DAC_MID;
        case (cmd)
            drbm_pkg::CMD_PUSH: begin
                if (trk) begin
                    if (effect_wr - effect_rd == 12'hFFF)
                        r.byte_dropped = 1'b1;
                    else begin
                        effect_bytes[effect_wr] = data;
                        effect_wr = effect_wr + 12'd1;
                    end
                end else begin
                    if (music_wr - music_rd == 12'hFFF)
                        r.byte_dropped = 1'b1;
                    else begin
                        music_bytes[music_wr] = data;
                        music_wr = music_wr + 12'd1;
                    end
                end
            end
            drbm_pkg::CMD_TICK: begin
                m = pop_sample(drbm_pkg::TRACK_MUSIC);
                e = 0;
                if (playing) begin
                    if (active_bits[drbm_pkg::TRACK_EFFECT])
                        e = pop_sample(drbm_pkg::TRACK_EFFECT);
                    else
                        playing = 1'b0;
                end
                mixed = (m >>> music_sh) + (e >>> effect_sh) + int'(drbm_pkg::MIX_OFFSET);
                if (mixed < 0)
                    r.dac = '0;
                else if ((mixed >>> 4) > int'(drbm_pkg::DAC_MAX))
                    r.dac = drbm_pkg::DAC_MAX;
                else
                    r.dac = mixed[15:4];
                r.sample_valid = 1'b1;
            end
            drbm_pkg::CMD_START: begin
                if (trk) begin
                    effect_rd = '0;
                    effect_wr = '0;
                    playing   = 1'b1;
                end else begin
                    music_rd = '0;
                    music_wr = '0;
                end
                active_bits[trk] = 1'b1;
                loop_bits[trk]   = lp;
            end
            drbm_pkg::CMD_END:  loop_bits[trk] = 1'b0;
            drbm_pkg::CMD_STOP: begin
                active_bits = '0;
                playing     = 1'b0;
            end
            default: ;
        endcase
        r.music_level    = music_wr - music_rd;
        r.effect_level   = effect_wr - effect_rd;
        r.music_active   = active_bits[drbm_pkg::TRACK_MUSIC];
        r.effect_active  = active_bits[drbm_pkg::TRACK_EFFECT];
        r.effect_playing = playing;
        expected_mix_q.push_back(r);
    endfunction

    function automatic string show_mix(input mix_result_t r);
        return $sformatf("dac=%0d sv=%0d ml=%0d el=%0d ma=%0d ea=%0d ep=%0d drop=%0d",
                         r.dac, r.sample_valid, r.music_level, r.effect_level,
                         r.music_active, r.effect_active, r.effect_playing,
                         r.byte_dropped);
    endfunction

    // result checker and receiver stalls
    always @(posedge aclk) begin : check_results
        mix_result_t got;
        mix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.dac            = m_tdata[11:0];
            got.sample_valid   = m_tuser;
            got.music_level    = m_tdata[23:12];
            got.effect_level   = m_tdata[35:24];
            got.music_active   = m_tdata[36];
            got.effect_active  = m_tdata[37];
            got.effect_playing = m_tdata[38];
            got.byte_dropped   = m_tdata[39];
            if (expected_mix_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: %s", show_mix(got));
            end else begin
                want = expected_mix_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch expected: %s", show_mix(want));
                        $display("mismatch actual:   %s", show_mix(got));
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // send one item; tvalid stays high after acceptance
    task automatic send_command(input logic [2:0] cmd, input logic trk,
                                input logic [7:0] data, input logic lp);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tuser  <= {trk, cmd};
        s_tdata  <= {7'd0, lp, data};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mix_predict(cmd, trk, data, lp);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_mix_q.size() != 0);
    endtask

    // write both shift registers, only while idle
    task automatic write_shifts(input logic [3:0] m_sh, input logic [3:0] e_sh);
        cfg_index <= drbm_pkg::REG_MUSIC_SHIFT;
        cfg_data  <= m_sh;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        music_sh = m_sh;
        cfg_index <= drbm_pkg::REG_EFFECT_SHIFT;
        cfg_data  <= e_sh;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        effect_sh = e_sh;
        cfg_valid <= 1'b0;
    endtask

    // prime both rings, then stream pushes and ticks at two shift settings
    task automatic test_streaming;
        send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_EFFECT, 8'h00, 1'b0);
        repeat (64)
            send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC,
                         8'($urandom_range(255)), 1'b0);
        repeat (64)
            send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_EFFECT,
                         8'($urandom_range(255)), 1'b0);
        for (int half = 0; half < 2; half++) begin
            repeat (60) begin
                send_command(drbm_pkg::CMD_TICK, 1'($urandom_range(1)),
                             8'($urandom_range(255)), 1'b0);
                repeat (2)
                    send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC,
                                 8'($urandom_range(255)), 1'b0);
                repeat (2)
                    send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_EFFECT,
                                 8'($urandom_range(255)), 1'b0);
            end
            drain_results();
            if (half == 0)
                write_shifts(4'd15, 4'd15);
        end
    endtask

    // saturation, running dry, looping, source end, unused codes, stop all
    task automatic test_directed_cases;
        write_shifts(4'd0, 4'd0);
        send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_EFFECT, 8'h00, 1'b0);
        // full-scale positive on both tracks saturates high
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC, 8'hFF, 1'b0);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC, 8'h7F, 1'b0);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_EFFECT, 8'hFF, 1'b0);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_EFFECT, 8'h7F, 1'b0);
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        // full-scale negative saturates low
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b1);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC, 8'h80, 1'b1);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_EFFECT, 8'h00, 1'b1);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_EFFECT, 8'h80, 1'b1);
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_EFFECT, 8'hFF, 1'b1);
        // empty tracks go inactive, then the playing flag clears
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        // looping track stays active while dry, single byte is not a sample
        send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b1);
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(drbm_pkg::CMD_PUSH, drbm_pkg::TRACK_MUSIC, 8'hA5, 1'b0);
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(drbm_pkg::CMD_END, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(drbm_pkg::CMD_TICK, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        send_command(CMD_UNUSED_LO, drbm_pkg::TRACK_EFFECT, 8'hFF, 1'b1);
        send_command(CMD_UNUSED_HI, drbm_pkg::TRACK_MUSIC, 8'h5A, 1'b0);
        send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_EFFECT, 8'h00, 1'b1);
        send_command(drbm_pkg::CMD_STOP, drbm_pkg::TRACK_MUSIC, 8'h00, 1'b0);
        drain_results();
    endtask

    // random sessions: mostly start-feed-play sequences, some raw noise
    task automatic run_random_items(input int budget);
        int         sent;
        int         pick;
        logic [2:0] cmd;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 8) begin
                drain_results();
                write_shifts(4'($urandom_range(15)), 4'($urandom_range(15)));
            end
            if ($urandom_range(99) < 80) begin
                send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_MUSIC,
                             8'($urandom_range(255)), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    send_command(drbm_pkg::CMD_START, drbm_pkg::TRACK_EFFECT,
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                sent += 2;
                repeat ($urandom_range(40, 8)) begin
                    pick = $urandom_range(99);
                    if (pick < 55)
                        cmd = drbm_pkg::CMD_PUSH;
                    else if (pick < 88)
                        cmd = drbm_pkg::CMD_TICK;
                    else if (pick < 93)
                        cmd = drbm_pkg::CMD_END;
                    else if (pick < 97)
                        cmd = drbm_pkg::CMD_START;
                    else
                        cmd = drbm_pkg::CMD_STOP;
                    send_command(cmd, 1'($urandom_range(1)), 8'($urandom_range(255)),
                                 1'($urandom_range(1)));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(10, 1)) begin
                    cmd = 3'($urandom_range(7));
                    send_command(cmd, 1'($urandom_range(1)), 8'($urandom_range(255)),
                                 1'($urandom_range(1)));
                    if (cmd < CMD_UNUSED_LO)
                        sent++;
                end
            end
        end
        drain_results();
    endtask

    task automatic test_random_sessions;
        run_random_items(480);
    endtask

    // back-to-back traffic with neither side stalling
    task automatic test_no_idle_stretch;
        idle_pct = 0;
        run_random_items(200);
        idle_pct = 28;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tvalid  <= 1'b0;
        m_tready  <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cfg_valid <= 1'b0;
        music_rd    = '0;
        music_wr    = '0;
        effect_rd   = '0;
        effect_wr   = '0;
        active_bits = '0;
        loop_bits   = '0;
        playing     = 1'b0;
        music_sh    = drbm_pkg::MUSIC_SHIFT_RST;
        effect_sh   = drbm_pkg::EFFECT_SHIFT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_streaming();
        test_directed_cases();
        test_random_sessions();
        test_no_idle_stretch();

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_mix_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
hdl/drbm_pkg.sv
hdl/dual_ring_buffer_audio_mixer.sv
hdl/drbm_checker.sv
sim/testbench.sv
